[design/crbs_pkg.sv]
// ----------------------------------------------------------------------------
// crbs_pkg
// Shared types and constants for the coil region bit store.
// ----------------------------------------------------------------------------
package crbs_pkg;

	localparam int COIL_ADDR_W = 16;
	localparam int COUNT_W     = 16;
	localparam int REGION_W    = 3;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_STARTS  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LENGTHS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_IN_USE  = 2'd2;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] starts;
		logic [CFG_DATA_W-1:0] lengths;
		logic [REGION_W-1:0]   in_use;
	} cfg_t;

	// one classified coil request, byte address travels beside it
	typedef struct packed {
		logic               mapped;
		logic               action;
		logic               write_bit;
		logic [2:0]         bit_sel;
		logic [COUNT_W-1:0] served_count;
	} cmd_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_WRITE
	} back_state_t;

endpackage

[design/coil_region_bit_store.sv]
// ----------------------------------------------------------------------------
// coil_region_bit_store
// Bank of on/off coils mapped into up to four configured address regions.
// ----------------------------------------------------------------------------
// Each request on the input channel is one coil of a read or write. A request
// with first set restarts the walk at coil_address; later requests take the
// next address. The walker keeps the current region and only steps forward
// through the region table; once no region matches, the rest of the walk is
// unmapped until the next first request.
// Every request gives exactly one result: mapped, read_bit, served_count.
// An accepted request passes through the queue, the store read registers and
// the result register before out_valid. The store sequencer takes the next
// request only after the read-then-write of one store byte for the last one.
// After reset all (REGIONS*REGION_BITS+7)/8 store bytes are cleared, one byte
// a cycle, with in_ready low; configuration writes are taken at any time.
// A stalled out_ready holds the result; the two-entry queue keeps accepting
// until it fills, then in_ready drops.
// ----------------------------------------------------------------------------
module coil_region_bit_store #(
	parameter int REGIONS     = 4,
	parameter int REGION_BITS = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [crbs_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [crbs_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 action,
	input  logic                                 first,
	input  logic [crbs_pkg::COIL_ADDR_W-1:0]     coil_address,
	input  logic                                 write_bit,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 mapped,
	output logic                                 read_bit,
	output logic [crbs_pkg::COUNT_W-1:0]         served_count
);

	localparam int TOT_W  = $clog2(REGIONS * REGION_BITS);
	localparam int ADDR_W = (TOT_W > 3) ? TOT_W - 3 : 1;
	localparam int Q_W    = $bits(crbs_pkg::cmd_t) + ADDR_W;

	crbs_pkg::cfg_t    cfg_q;

	logic              enable;
	logic              q_full;
	logic              q_not_empty;
	logic              push;
	logic              pop;
	crbs_pkg::cmd_t    front_cmd;
	logic [ADDR_W-1:0] front_addr;
	logic [Q_W-1:0]    q_rd_data;
	crbs_pkg::cmd_t    back_cmd;
	logic [ADDR_W-1:0] back_addr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				crbs_pkg::REG_STARTS:  cfg_q.starts  <= cfg_data;
				crbs_pkg::REG_LENGTHS: cfg_q.lengths <= cfg_data;
				crbs_pkg::REG_IN_USE:  cfg_q.in_use  <= cfg_data[crbs_pkg::REGION_W-1:0];
				default: ;
			endcase
		end
	end

	crbs_front #(
		.REGIONS     (REGIONS),
		.REGION_BITS (REGION_BITS),
		.ADDR_W      (ADDR_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.enable       (enable),
		.q_full       (q_full),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.first        (first),
		.coil_address (coil_address),
		.write_bit    (write_bit),
		.push         (push),
		.cmd          (front_cmd),
		.byte_addr    (front_addr)
	);

	crbs_fifo #(
		.WIDTH (Q_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   ({front_cmd, front_addr}),
		.pop       (pop),
		.rd_data   (q_rd_data),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	assign back_cmd  = q_rd_data[Q_W-1:ADDR_W];
	assign back_addr = q_rd_data[ADDR_W-1:0];

	crbs_back #(
		.REGIONS     (REGIONS),
		.REGION_BITS (REGION_BITS),
		.ADDR_W      (ADDR_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_not_empty),
		.q_cmd        (back_cmd),
		.q_addr       (back_addr),
		.q_pop        (pop),
		.enable       (enable),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mapped       (mapped),
		.read_bit     (read_bit),
		.served_count (served_count)
	);

endmodule

[design/crbs_fifo.sv]
// ----------------------------------------------------------------------------
// crbs_fifo
// Short request queue between the classifier and the store sequencer.
// ----------------------------------------------------------------------------
module crbs_fifo #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             not_empty
);

	localparam int PTR_W = (crbs_pkg::QUEUE_DEPTH > 1) ? $clog2(crbs_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(crbs_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(crbs_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(crbs_pkg::QUEUE_DEPTH);

	logic [WIDTH-1:0] slot_q [crbs_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_data   = slot_q[rd_ptr_q];
	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/crbs_front.sv]
// ----------------------------------------------------------------------------
// crbs_front
// Request walker: tracks the running address and region, matches the coil
// against the region table and hands a classified request to the queue.
// ----------------------------------------------------------------------------
module crbs_front #(
	parameter int REGIONS     = 4,
	parameter int REGION_BITS = 256,
	parameter int ADDR_W      = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  crbs_pkg::cfg_t                     cfg,
	input  logic                               enable,
	input  logic                               q_full,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	input  logic                               first,
	input  logic [crbs_pkg::COIL_ADDR_W-1:0]   coil_address,
	input  logic                               write_bit,
	output logic                               push,
	output crbs_pkg::cmd_t                     cmd,
	output logic [ADDR_W-1:0]                  byte_addr
);

	localparam int TOT_W = $clog2(REGIONS * REGION_BITS);
	localparam int OFF_W = $clog2(REGION_BITS);
	localparam logic [crbs_pkg::COIL_ADDR_W-1:0] REGION_SIZE =
		crbs_pkg::COIL_ADDR_W'(REGION_BITS);
	localparam logic [crbs_pkg::REGION_W-1:0] REGION_MAX = crbs_pkg::REGION_W'(REGIONS);

	logic [crbs_pkg::COIL_ADDR_W-1:0] walk_address_q;
	logic [crbs_pkg::REGION_W-1:0]    walk_region_q;
	logic                             walk_stopped_q;
	logic [crbs_pkg::COUNT_W-1:0]     served_total_q;

	logic [crbs_pkg::COIL_ADDR_W-1:0] cur_addr;
	logic [crbs_pkg::REGION_W-1:0]    cur_region;
	logic                             cur_stop;
	logic [crbs_pkg::COUNT_W-1:0]     cur_total;
	logic [crbs_pkg::REGION_W-1:0]    limit;

	logic [crbs_pkg::COIL_ADDR_W-1:0] start   [REGIONS];
	logic [crbs_pkg::COIL_ADDR_W-1:0] len     [REGIONS];
	logic [crbs_pkg::COIL_ADDR_W-1:0] len_sat [REGIONS];
	logic [crbs_pkg::COIL_ADDR_W-1:0] diff    [REGIONS];
	logic [REGIONS-1:0]               hit;

	logic                             found;
	logic [crbs_pkg::REGION_W-1:0]    sel_region;
	logic [OFF_W-1:0]                 sel_off;
	logic                             serve;
	logic [31:0]                      bit_full;
	logic [TOT_W-1:0]                 bit_index;
	logic [crbs_pkg::COUNT_W-1:0]     total_d;

	assign in_ready = enable && !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		cur_addr   = first ? coil_address : walk_address_q;
		cur_region = first ? '0 : walk_region_q;
		cur_stop   = first ? 1'b0 : walk_stopped_q;
		cur_total  = first ? '0 : served_total_q;
		limit      = (cfg.in_use > REGION_MAX) ? REGION_MAX : cfg.in_use;

		for (int r = 0; r < REGIONS; r++) begin
			start[r]   = cfg.starts[16*r +: 16];
			len[r]     = cfg.lengths[16*r +: 16];
			len_sat[r] = (len[r] > REGION_SIZE) ? REGION_SIZE : len[r];
			diff[r]    = cur_addr - start[r];
			hit[r]     = (crbs_pkg::REGION_W'(r) >= cur_region)
				&& (crbs_pkg::REGION_W'(r) < limit)
				&& (len[r] != '0)
				&& (cur_addr >= start[r])
				&& (diff[r] < len_sat[r]);
		end

		// lowest matching region from the current one onward
		found      = 1'b0;
		sel_region = '0;
		sel_off    = '0;
		for (int r = REGIONS - 1; r >= 0; r--) begin
			if (hit[r]) begin
				found      = 1'b1;
				sel_region = crbs_pkg::REGION_W'(r);
				sel_off    = diff[r][OFF_W-1:0];
			end
		end

		serve     = !cur_stop && found;
		bit_full  = 32'(sel_region) * 32'(REGION_BITS) + 32'(sel_off);
		bit_index = bit_full[TOT_W-1:0];
		byte_addr = ADDR_W'(bit_index >> 3);

		if (serve && (cur_total != '1)) begin
			total_d = cur_total + 1'b1;
		end else begin
			total_d = cur_total;
		end

		cmd.mapped       = serve;
		cmd.action       = action;
		cmd.write_bit    = write_bit;
		cmd.bit_sel      = bit_index[2:0];
		cmd.served_count = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_address_q <= '0;
			walk_region_q  <= '0;
			walk_stopped_q <= 1'b1;
			served_total_q <= '0;
		end else if (push) begin
			walk_address_q <= serve ? cur_addr + 1'b1 : cur_addr;
			walk_region_q  <= serve ? sel_region : cur_region;
			walk_stopped_q <= !serve;
			served_total_q <= total_d;
		end
	end

endmodule

[design/crbs_back.sv]
// ----------------------------------------------------------------------------
// crbs_back
// Store sequencer: clears the coil memory after reset, then reads one store
// byte per request, writes it back modified for a mapped write, and holds the result.
// ----------------------------------------------------------------------------
module crbs_back #(
	parameter int REGIONS     = 4,
	parameter int REGION_BITS = 256,
	parameter int ADDR_W      = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  crbs_pkg::cmd_t                 q_cmd,
	input  logic [ADDR_W-1:0]              q_addr,
	output logic                           q_pop,
	output logic                           enable,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           mapped,
	output logic                           read_bit,
	output logic [crbs_pkg::COUNT_W-1:0]   served_count
);

	localparam int STORE_BYTES = (REGIONS * REGION_BITS + 7) / 8;
	localparam logic [ADDR_W-1:0] LAST_BYTE = ADDR_W'(STORE_BYTES - 1);

	logic [7:0] coil_store_q [STORE_BYTES];

	crbs_pkg::back_state_t state_q, state_d;
	logic [ADDR_W-1:0]     clr_ptr_q;
	crbs_pkg::cmd_t        cmd_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [7:0]            rdata_s1;

	logic                  out_valid_q;
	logic                  mapped_q;
	logic                  read_bit_q;
	logic [crbs_pkg::COUNT_W-1:0] served_count_q;

	logic                  out_free;
	logic                  out_load;
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr;
	logic [7:0]            mem_wdata;
	logic [7:0]            bit_mask;

	assign out_free     = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign mapped       = mapped_q;
	assign read_bit     = read_bit_q;
	assign served_count = served_count_q;
	assign bit_mask     = 8'(1) << cmd_s1.bit_sel;

	always_comb begin
		state_d = state_q;
		case (state_q)
			crbs_pkg::B_CLEAR: begin
				if (clr_ptr_q == LAST_BYTE) begin
					state_d = crbs_pkg::B_IDLE;
				end
			end
			crbs_pkg::B_IDLE: begin
				if (q_valid) begin
					state_d = crbs_pkg::B_WRITE;
				end
			end
			crbs_pkg::B_WRITE: begin
				if (out_free) begin
					state_d = crbs_pkg::B_IDLE;
				end
			end
			default: state_d = crbs_pkg::B_CLEAR;
		endcase
	end

	always_comb begin
		enable    = 1'b1;
		q_pop     = 1'b0;
		out_load  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = cmd_s1.write_bit ? (rdata_s1 | bit_mask) : (rdata_s1 & ~bit_mask);
		case (state_q)
			crbs_pkg::B_CLEAR: begin
				enable    = 1'b0;
				mem_we    = 1'b1;
				mem_waddr = clr_ptr_q;
				mem_wdata = '0;
			end
			crbs_pkg::B_IDLE: begin
				q_pop = q_valid;
			end
			crbs_pkg::B_WRITE: begin
				out_load = out_free;
				mem_we   = out_free && cmd_s1.mapped && cmd_s1.action;
			end
			default: begin
				enable = 1'b0;
			end
		endcase
	end

	// store port: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			coil_store_q[mem_waddr] <= mem_wdata;
		end
		if (q_pop) begin
			rdata_s1 <= coil_store_q[q_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1  <= q_cmd;
			addr_s1 <= q_addr;
		end
		if (out_load) begin
			mapped_q       <= cmd_s1.mapped;
			read_bit_q     <= cmd_s1.mapped && !cmd_s1.action && rdata_s1[cmd_s1.bit_sel];
			served_count_q <= cmd_s1.served_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= crbs_pkg::B_CLEAR;
			clr_ptr_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == crbs_pkg::B_CLEAR) begin
				clr_ptr_q <= clr_ptr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[tb/coil_region_bit_store_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coil_region_bit_store_test
// Self-checking bench for the coil region bit store. Coil read/write requests
// are offered in random bursts while the result side stalls on its own
// pattern. Each accepted request is run through a shadow copy of the region
// walk and the coil bank, and every result is checked in order against it.
// Region tables are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module coil_region_bit_store_test;

	localparam int REGIONS      = 4;
	localparam int REGION_BITS  = 256;
	localparam int COIL_COUNT   = REGIONS * REGION_BITS;
	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE       = 8;
	localparam int LONG_HOLD    = 300;
	localparam int PHASES       = 6;
	localparam logic [crbs_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic                             action;
		logic                             first;
		logic [crbs_pkg::COIL_ADDR_W-1:0] addr;
		logic                             wbit;
	} coil_req_t;

	typedef struct packed {
		logic                         mapped;
		logic                         read_bit;
		logic [crbs_pkg::COUNT_W-1:0] served_count;
	} coil_res_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [crbs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [crbs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	logic first = 1'b0;
	logic [crbs_pkg::COIL_ADDR_W-1:0] coil_address = '0;
	logic write_bit = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic mapped;
	logic read_bit;
	logic [crbs_pkg::COUNT_W-1:0] served_count;

	coil_region_bit_store #(
		.REGIONS(REGIONS),
		.REGION_BITS(REGION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.first(first),
		.coil_address(coil_address),
		.write_bit(write_bit),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mapped(mapped),
		.read_bit(read_bit),
		.served_count(served_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the region table
	logic [crbs_pkg::CFG_DATA_W-1:0] shadow_starts = '0;
	logic [crbs_pkg::CFG_DATA_W-1:0] shadow_lengths = '0;
	logic [crbs_pkg::REGION_W-1:0] shadow_in_use = '0;

	// shadow of the walk and the coil bank
	logic [crbs_pkg::COIL_ADDR_W-1:0] walk_addr = '0;
	int walk_reg = 0;
	logic walk_stop = 1'b1;
	logic [crbs_pkg::COUNT_W-1:0] served_so_far = '0;
	logic coil_bank [0:COIL_COUNT-1];

	coil_req_t coil_requests[$];
	coil_res_t due_results[$];

	int pushed_count = 0;
	int accepted_count = 0;
	int mapped_seen = 0;
	int fail_count = 0;
	int hold_seq = 0;
	logic in_fired = 1'b0;

	initial begin
		for (int i = 0; i < COIL_COUNT; i++)
			coil_bank[i] = 1'b0;
	end

	function automatic int clamped_len(int r);
		int n;
		n = int'(shadow_lengths[16*r +: 16]);
		if (n > REGION_BITS)
			n = REGION_BITS;
		return n;
	endfunction

	function automatic bit region_covers(int r, logic [crbs_pkg::COIL_ADDR_W-1:0] a);
		int s, n, ai;
		s = int'(shadow_starts[16*r +: 16]);
		n = clamped_len(r);
		ai = int'(a);
		return (n != 0) && (ai >= s) && ((ai - s) < n);
	endfunction

	function automatic coil_res_t predict_access(coil_req_t q);
		coil_res_t res;
		int r, lim, bitpos, s;
		res = '0;
		lim = (int'(shadow_in_use) > REGIONS) ? REGIONS : int'(shadow_in_use);
		if (q.first) begin
			walk_addr = q.addr;
			walk_reg = 0;
			walk_stop = 1'b0;
			served_so_far = '0;
		end
		if (!walk_stop) begin
			r = walk_reg;
			while (r < lim && !region_covers(r, walk_addr))
				r++;
			if (r >= lim) begin
				walk_stop = 1'b1;
			end else begin
				s = int'(shadow_starts[16*r +: 16]);
				bitpos = r * REGION_BITS + (int'(walk_addr) - s);
				walk_reg = r;
				if (q.action)
					coil_bank[bitpos] = q.wbit;
				else
					res.read_bit = coil_bank[bitpos];
				res.mapped = 1'b1;
				if (served_so_far != '1)
					served_so_far = served_so_far + 1'b1;
				walk_addr = walk_addr + 1'b1;
			end
		end
		res.served_count = served_so_far;
		return res;
	endfunction

	// sender: bursts of random length with random gaps
	int burst_left = 0;
	int gap_left = 0;
	coil_req_t offered;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fired) begin
			// request still waiting, hold it
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (coil_requests.size() > 0) begin
			offered = coil_requests.pop_front();
			in_valid <= 1'b1;
			action <= offered.action;
			first <= offered.first;
			coil_address <= offered.addr;
			write_bit <= offered.wbit;
			if (burst_left <= 1) begin
				burst_left = int'($urandom_range(1, 24));
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
			end else begin
				burst_left--;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: stall pattern of its own, plus one long hold-off on demand
	rx_mode_t rx_mode = RX_OPEN;
	int rx_left = 0;
	int rx_tick = 0;
	int hold_seen = 0;
	int hold_left = 0;

	always @(negedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen = hold_seq;
			hold_left = LONG_HOLD;
		end
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = int'($urandom_range(16, 96));
		end else begin
			rx_left--;
		end
		rx_tick++;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ((rx_tick % 5) < 3);
			endcase
		end
	end

	// monitor: check results, predict on each accepted request
	always @(posedge clk) begin : monitor
		coil_res_t got, want;
		coil_req_t taken;
		in_fired <= in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			got = '{mapped, read_bit, served_count};
			if (due_results.size() == 0) begin
				fail_count++;
				$display("%0t: expected nothing, actual mapped=%0b read_bit=%0b count=%0d",
					$time, got.mapped, got.read_bit, got.served_count);
			end else begin
				want = due_results.pop_front();
				if (got.mapped)
					mapped_seen++;
				if (got !== want) begin
					fail_count++;
					$display("%0t: expected %0b/%0b/%0d, actual %0b/%0b/%0d (mapped/read/count)",
						$time, want.mapped, want.read_bit, want.served_count,
						got.mapped, got.read_bit, got.served_count);
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			taken = '{action, first, coil_address, write_bit};
			due_results.push_back(predict_access(taken));
			accepted_count++;
		end
	end

	initial begin : watchdog
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
		$display("TEST FAILED");
		$finish;
	end

	task automatic write_reg(input logic [crbs_pkg::CFG_INDEX_W-1:0] idx,
			input logic [crbs_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			crbs_pkg::REG_STARTS: shadow_starts = val;
			crbs_pkg::REG_LENGTHS: shadow_lengths = val;
			crbs_pkg::REG_IN_USE: shadow_in_use = val[crbs_pkg::REGION_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_table(input logic [crbs_pkg::CFG_DATA_W-1:0] st,
			input logic [crbs_pkg::CFG_DATA_W-1:0] ln,
			input logic [crbs_pkg::REGION_W-1:0] n_in_use);
		write_reg(crbs_pkg::REG_STARTS, st);
		write_reg(crbs_pkg::REG_LENGTHS, ln);
		write_reg(crbs_pkg::REG_IN_USE, crbs_pkg::CFG_DATA_W'(n_in_use));
	endtask

	task automatic push_item(input logic act, input logic fst,
			input logic [crbs_pkg::COIL_ADDR_W-1:0] a, input logic wb);
		coil_requests.push_back('{act, fst, a, wb});
		pushed_count++;
	endtask

	// wait until every request is taken and answered, then let the block settle
	task automatic drain();
		do @(negedge clk); while (accepted_count != pushed_count || due_results.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic int pick_len();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return int'($urandom_range(1, 8));
			2: return int'($urandom_range(9, 255));
			3: return REGION_BITS;
			4: return int'($urandom_range(257, 65535));
			default: return 65535;
		endcase
	endfunction

	task automatic random_table();
		logic [crbs_pkg::CFG_DATA_W-1:0] st, ln;
		logic [crbs_pkg::REGION_W-1:0] nu;
		int s, n, nc, kind;
		kind = int'($urandom_range(0, 3));
		s = int'($urandom_range(0, 65535));
		for (int i = 0; i < REGIONS; i++) begin
			n = pick_len();
			nc = (n > REGION_BITS) ? REGION_BITS : n;
			if (kind == 2)
				st[16*i +: 16] = 16'(s + int'($urandom_range(0, 32)));
			else
				st[16*i +: 16] = 16'(s);
			ln[16*i +: 16] = 16'(n);
			// now and then a region sits below the previous one
			if (kind != 2) begin
				if ($urandom_range(0, 4) == 0)
					s = int'($urandom_range(0, 65535));
				else
					s = (s + nc + int'($urandom_range(0, 2))) & 16'hFFFF;
			end
		end
		case (kind)
			0: nu = 3'($urandom_range(1, 4));
			1: begin
				st = {$urandom, $urandom};
				ln = {$urandom, $urandom};
				nu = 3'($urandom_range(0, 7));
			end
			2: nu = 3'(REGIONS);
			default: nu = 3'($urandom_range(5, 7));
		endcase
		load_table(st, ln, nu);
	endtask

	task automatic push_walk(input int room);
		int r, s, len, cnt;
		logic [crbs_pkg::COIL_ADDR_W-1:0] a;
		logic act, mixed;
		r = int'($urandom_range(0, REGIONS - 1));
		s = int'(shadow_starts[16*r +: 16]);
		len = clamped_len(r);
		case ($urandom_range(0, 9))
			7: a = 16'($urandom_range(0, 65535));
			8: a = 16'(16'hFFFF - $urandom_range(0, 3));
			9: a = 16'(s - int'($urandom_range(1, 3)));
			default: a = (len == 0) ? 16'($urandom_range(0, 65535))
				: 16'(s + int'($urandom_range(0, len - 1)));
		endcase
		cnt = ($urandom_range(0, 5) == 0) ? int'($urandom_range(20, 300))
			: int'($urandom_range(1, 12));
		if (cnt > room)
			cnt = room;
		act = 1'($urandom_range(0, 1));
		mixed = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < cnt; i++)
			push_item(mixed ? 1'($urandom_range(0, 1)) : act, i == 0,
				(i == 0) ? a : crbs_pkg::COIL_ADDR_W'($urandom_range(0, 65535)),
				1'($urandom_range(0, 1)));
	endtask

	task automatic random_traffic(input int n_items);
		int goal;
		goal = pushed_count + n_items;
		while (pushed_count < goal) begin
			if ($urandom_range(0, 9) == 0)
				push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
			else
				push_walk(goal - pushed_count);
		end
	endtask

	initial begin : stimulus
		int phase;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset table: nothing is searched, and no request is active yet
		push_item(1'b0, 1'b0, 16'h1234, 1'b0);
		push_item(1'b1, 1'b1, 16'h0000, 1'b1);
		push_item(1'b0, 1'b0, 16'hFFFF, 1'b1);
		drain();

		// r0 0x10+16, r1 empty, r2 0x20 with oversize length, r3 running past the top
		load_table({16'hFF80, 16'h0020, 16'h0100, 16'h0010},
			{16'h0100, 16'hFFFF, 16'h0000, 16'h0010}, 3'd4);
		write_reg(REG_SPARE, '1);
		push_item(1'b1, 1'b1, 16'h001E, 1'b1);
		push_item(1'b1, 1'b0, 16'hFFFF, 1'b0);
		push_item(1'b1, 1'b0, 16'h0000, 1'b1);
		push_item(1'b0, 1'b1, 16'h001E, 1'b0);
		push_item(1'b0, 1'b0, 16'h5555, 1'b1);
		push_item(1'b0, 1'b0, 16'hAAAA, 1'b0);
		// top address, then the walk wraps to zero and stops
		push_item(1'b1, 1'b1, 16'hFFFF, 1'b1);
		push_item(1'b0, 1'b0, 16'h0000, 1'b0);
		push_item(1'b1, 1'b0, 16'h0000, 1'b1);
		push_item(1'b0, 1'b1, 16'hFFFF, 1'b0);
		push_item(1'b0, 1'b1, 16'h0100, 1'b0);
		push_item(1'b1, 1'b1, 16'h0000, 1'b1);
		push_item(1'b0, 1'b1, 16'h001F, 1'b1);
		push_item(1'b1, 1'b0, 16'h0000, 1'b0);
		push_item(1'b0, 1'b1, 16'h0020, 1'b1);
		drain();

		// region count above the table size
		write_reg(crbs_pkg::REG_IN_USE, crbs_pkg::CFG_DATA_W'(3'd7));
		random_traffic(20);
		drain();

		phase = 0;
		while (phase < PHASES) begin
			random_table();
			// first phase: result side holds off long enough to back up the input
			if (phase == 0)
				hold_seq++;
			random_traffic(90);
			drain();
			phase++;
		end

		load_table('1, '1, 3'd7);
		random_traffic(40);
		drain();
		load_table('0, '0, 3'd0);
		random_traffic(30);
		drain();
		load_table('0, '1, 3'd4);
		random_traffic(40);
		drain();

		$display("%0d coil requests checked over %0d random tables plus directed and extreme ones",
			accepted_count, phase);
		$display("%0d of them served by a region, %0d mismatches", mapped_seen, fail_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
design/crbs_pkg.sv
design/crbs_fifo.sv
design/crbs_front.sv
design/crbs_back.sv
design/coil_region_bit_store.sv
tb/coil_region_bit_store_test.sv
